/* rtl/core/anchor_chain_dp_scorer_assert.svh */
// Assertion macros used by the checker file of the scorer.
`ifndef ANCHOR_CHAIN_DP_SCORER_ASSERT_SVH
`define ANCHOR_CHAIN_DP_SCORER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACDS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACDS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/acds_pkg.sv */
`default_nettype none
package acds_pkg;

	localparam int SCORE_W = 48;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_REF_GAP     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_QUERY_GAP   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_LIMIT      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_SCALE_Q16   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CDNA_MODE       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_SEGMENT   = 4'd7;

	localparam logic [31:0] NO_PRED = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		RD_ST,
		RD_J,
		RD_MAXJ
	} rd_sel_t;

	typedef struct packed {
		logic    load_item;
		logic    clamp;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    slide_step;
		logic    walk_init;
		logic    stage_b;
		logic    stage_c;
		logic    stage_d;
		logic    peak_chk;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic st_ne_i;
		logic slide;
		logic cnt_zero;
		logic brk;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/core/acds_ctrl.sv */
`default_nettype none
module acds_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire acds_pkg::sts_t sts,
	output acds_pkg::cmd_t     cmd
);
	import acds_pkg::*;

	typedef enum logic [3:0] {
		IDLE,
		CLAMP,
		SL_RD,
		SL_CHK,
		W_INIT,
		W_RD,
		W_B,
		W_C,
		W_D,
		PK_RD,
		PK_CHK,
		FIN
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_ST;
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = CLAMP;
				end
			end
			CLAMP: begin
				cmd.clamp = 1'b1;
				state_d = SL_RD;
			end
			SL_RD: begin
				if (sts.st_ne_i) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_ST;
					state_d = SL_CHK;
				end else begin
					state_d = W_INIT;
				end
			end
			SL_CHK: begin
				if (sts.slide) begin
					cmd.slide_step = 1'b1;
					state_d = SL_RD;
				end else begin
					state_d = W_INIT;
				end
			end
			W_INIT: begin
				cmd.walk_init = 1'b1;
				state_d = W_RD;
			end
			W_RD: begin
				if (sts.cnt_zero) begin
					state_d = PK_RD;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_J;
					state_d = W_B;
				end
			end
			W_B: begin
				cmd.stage_b = 1'b1;
				state_d = W_C;
			end
			W_C: begin
				cmd.stage_c = 1'b1;
				state_d = W_D;
			end
			W_D: begin
				cmd.stage_d = 1'b1;
				state_d = sts.brk ? PK_RD : W_RD;
			end
			PK_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_MAXJ;
				state_d = PK_CHK;
			end
			PK_CHK: begin
				cmd.peak_chk = 1'b1;
				state_d = FIN;
			end
			FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/acds_dp.sv */
`default_nettype none
module acds_dp #(
	parameter int WINDOW_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [acds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                       cfg_data,
	input  wire logic [63:0]                       ref_key,
	input  wire logic signed [31:0]                query_pos,
	input  wire logic [7:0]                        query_span,
	input  wire logic [7:0]                        segment_id,
	input  wire logic                              last_of_read,
	input  wire acds_pkg::cmd_t                    cmd,
	output acds_pkg::sts_t                         sts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [31:0]                     chain_score,
	output logic signed [31:0]                     pred_index,
	output logic signed [31:0]                     peak_score
);
	import acds_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
	localparam logic [31:0] DEPTH32 = 32'(WINDOW_DEPTH);
	localparam logic signed [63:0] CAP64 = 64'sh0000_0100_0000_0000;
	localparam logic signed [41:0] DR_CAP = 42'sh100_0000_0000;
	localparam logic signed [SCORE_W-1:0] S32_MAX = 48'sh0000_7FFF_FFFF;
	localparam logic signed [SCORE_W-1:0] S32_MIN = -48'sh0000_8000_0000;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] qpos;
		logic [7:0]  seg;
		logic [31:0] score;
		logic [31:0] pred;
		logic [31:0] peak;
	} ent_t;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_sub(input logic [AW-1:0] s, input logic [CW-1:0] b);
		logic [31:0] t;
		t = 32'(s) - 32'(b);
		if (32'(s) < 32'(b)) begin
			t = t + DEPTH32;
		end
		return t[AW-1:0];
	endfunction

	// Configuration registers.
	logic [30:0] mrg_q, mqg_q, band_q;
	logic [15:0] skl_q;
	logic [6:0]  itl_q;
	logic [17:0] gs_q;
	logic        cdna_q, multi_q;

	// Read-level state.
	logic [31:0]   i_q, st_q;
	logic [AW-1:0] i_slot_q, st_slot_q;
	logic          out_valid_q;

	// Per-item work registers.
	logic [63:0]               ri_q;
	logic [31:0]               qi_q;
	logic [7:0]                qspan_q, sid_q;
	logic                      last_q;
	logic signed [SCORE_W-1:0] max_f_q;
	logic [31:0]               max_j_q, j_q;
	logic [AW-1:0]             maxj_slot_q, j_slot_q;
	logic [16:0]               nskip_q;
	logic [CW-1:0]             span_q, cnt_q;
	logic [31:0]               fi_q, peak_q;
	logic [31:0]               chain_q, pred_q, peakout_q;

	// Window storage.
	ent_t        win_q [WINDOW_DEPTH];
	logic [31:0] mark_q [WINDOW_DEPTH];
	ent_t        ent_rd_q;
	logic [31:0] mark_rd_q;

	// Walk pipeline registers.
	logic signed [41:0] dr_s1;
	logic signed [32:0] dq_s1;
	logic [41:0]        dd_s1;
	logic               same_s1, rej_s1;
	logic signed [41:0] sc0_s2;
	logic [5:0]         clog_s2;
	logic [43:0]        clin_s2;
	logic               same_s2, drz_s2, drgt_s2, rej_s2;

	// Combinational signals.
	logic [AW-1:0]      rd_addr;
	logic [CW-1:0]      lim;
	logic [31:0]        st_dist;
	logic [63:0]        diff;
	logic signed [41:0] dr_b;
	logic signed [32:0] dq_b;
	logic signed [42:0] ddiff;
	logic [41:0]        dd_b;
	logic               same_b, rej_b;
	logic signed [41:0] dq42, min_d, spn, sc0_c;
	logic [5:0]         clog_c;
	logic [59:0]        prod;
	logic               rej_c;
	logic signed [SCORE_W-1:0] lin, lg, minc, full, sc;
	logic               better, mark_hit, brk;
	logic [31:0]        back;
	logic               mark_ok;
	logic               mark_we;
	logic [AW-1:0]      mark_waddr;
	logic [31:0]        mark_wdata;
	logic [31:0]        fi_c, peak_c;
	logic [31:0]        walk_span;

	always_comb begin
		case (cmd.rd_sel)
			RD_ST:   rd_addr = st_slot_q;
			RD_J:    rd_addr = j_slot_q;
			RD_MAXJ: rd_addr = maxj_slot_q;
			default: rd_addr = st_slot_q;
		endcase
	end

	always_comb begin
		if (32'(itl_q) > DEPTH32) begin
			lim = CW'(WINDOW_DEPTH);
		end else begin
			lim = CW'(itl_q);
		end
		st_dist = i_q - st_q;
		walk_span = i_q - st_q;
	end

	// First walk stage: distances, segment match and the cheap rejections.
	always_comb begin
		diff = ri_q - ent_rd_q.key;
		if ($signed(diff) > CAP64) begin
			dr_b = DR_CAP;
		end else if ($signed(diff) < -CAP64) begin
			dr_b = -DR_CAP;
		end else begin
			dr_b = $signed(diff[41:0]);
		end
		dq_b = $signed({qi_q[31], qi_q}) - $signed({ent_rd_q.qpos[31], ent_rd_q.qpos});
		same_b = ent_rd_q.seg == sid_q;
		rej_b = (same_b && dr_b == 42'sd0) || (dq_b <= 33'sd0)
			|| (same_b && dq_b > $signed({2'b00, mqg_q}))
			|| (dq_b > $signed({2'b00, mrg_q}));
		ddiff = 43'(dr_b) - 43'(dq_b);
		dd_b = ddiff[42] ? 42'(-ddiff) : 42'(ddiff);
	end

	// Second walk stage: band checks, base score, log and linear gap cost.
	always_comb begin
		dq42 = 42'(dq_s1);
		rej_c = rej_s1 || (same_s1 && dd_s1 > {11'b0, band_q})
			|| (multi_q && !cdna_q && same_s1 && dr_s1 > $signed({11'b0, mqg_q}));
		min_d = (dq42 < dr_s1) ? dq42 : dr_s1;
		spn = $signed({34'b0, qspan_q});
		sc0_c = (min_d > spn) ? spn : min_d;
		clog_c = '0;
		for (int b = 1; b < 42; b++) begin
			if (dd_s1[b]) begin
				clog_c = 6'(b);
			end
		end
		prod = 60'(dd_s1) * 60'(gs_q);
	end

	// Third walk stage: candidate score, best update and skip bookkeeping.
	always_comb begin
		lin = $signed({4'b0, clin_s2});
		lg = $signed(48'(clog_s2));
		minc = (lin < lg) ? lin : lg;
		full = lin + $signed(48'(clog_s2 >> 1));
		sc = 48'(sc0_s2);
		if (cdna_q || !same_s2) begin
			if (!same_s2 && drz_s2) begin
				sc = sc + 48'sd1;
			end else if (drgt_s2 || !same_s2) begin
				sc = sc - minc;
			end else begin
				sc = sc - full;
			end
		end else begin
			sc = sc - full;
		end
		sc = sc + 48'($signed(ent_rd_q.score));
		better = sc > max_f_q;
		mark_hit = mark_rd_q == i_q;
		brk = !rej_s2 && !better && mark_hit && ((nskip_q + 17'd1) > {1'b0, skl_q});
		back = i_q - ent_rd_q.pred;
		mark_ok = !rej_s2 && !brk && (ent_rd_q.pred != NO_PRED)
			&& (back >= 32'd1) && (back <= 32'(span_q));
	end

	always_comb begin
		if (max_f_q > S32_MAX) begin
			fi_c = 32'h7FFF_FFFF;
		end else if (max_f_q < S32_MIN) begin
			fi_c = 32'h8000_0000;
		end else begin
			fi_c = max_f_q[31:0];
		end
		if ((max_j_q != NO_PRED) && ($signed(ent_rd_q.peak) > $signed(fi_c))) begin
			peak_c = ent_rd_q.peak;
		end else begin
			peak_c = fi_c;
		end
	end

	always_comb begin
		mark_we = 1'b0;
		mark_waddr = i_slot_q;
		mark_wdata = '0;
		if (cmd.finish) begin
			mark_we = 1'b1;
		end else if (cmd.stage_d && mark_ok) begin
			mark_we = 1'b1;
			mark_waddr = slot_sub(i_slot_q, back[CW-1:0]);
			mark_wdata = i_q;
		end
	end

	always_comb begin
		sts.st_ne_i = st_q != i_q;
		sts.slide = (ri_q > ent_rd_q.key) && ((ri_q - ent_rd_q.key) > {33'b0, mrg_q});
		sts.cnt_zero = cnt_q == '0;
		sts.brk = brk;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			ent_rd_q <= win_q[rd_addr];
			mark_rd_q <= mark_q[rd_addr];
		end
		if (cmd.finish) begin
			win_q[i_slot_q] <= '{key: ri_q, qpos: qi_q, seg: sid_q, score: fi_q,
				pred: max_j_q, peak: peak_q};
		end
		if (mark_we) begin
			mark_q[mark_waddr] <= mark_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrg_q <= 31'd5000;
			mqg_q <= 31'd5000;
			band_q <= 31'd500;
			skl_q <= 16'd25;
			itl_q <= 7'd64;
			gs_q <= 18'd9830;
			cdna_q <= 1'b0;
			multi_q <= 1'b0;
			i_q <= '0;
			st_q <= '0;
			i_slot_q <= '0;
			st_slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MAX_REF_GAP:     mrg_q <= cfg_data[30:0];
					REG_MAX_QUERY_GAP:   mqg_q <= cfg_data[30:0];
					REG_BAND_WIDTH:      band_q <= cfg_data[30:0];
					REG_SKIP_LIMIT:      skl_q <= cfg_data[15:0];
					REG_ITERATION_LIMIT: itl_q <= cfg_data[6:0];
					REG_GAP_SCALE_Q16:   gs_q <= cfg_data[17:0];
					REG_CDNA_MODE:       cdna_q <= cfg_data[0];
					REG_MULTI_SEGMENT:   multi_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.clamp && (st_dist > 32'(lim))) begin
				st_q <= i_q - 32'(lim);
				st_slot_q <= slot_sub(i_slot_q, lim);
			end
			if (cmd.slide_step) begin
				st_q <= st_q + 32'd1;
				st_slot_q <= slot_inc(st_slot_q);
			end
			if (out_valid_q && out_ready && !cmd.finish) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					i_q <= '0;
					st_q <= '0;
					i_slot_q <= '0;
					st_slot_q <= '0;
				end else begin
					i_q <= i_q + 32'd1;
					i_slot_q <= slot_inc(i_slot_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			ri_q <= ref_key;
			qi_q <= query_pos;
			qspan_q <= query_span;
			sid_q <= segment_id;
			last_q <= last_of_read;
			max_f_q <= $signed({40'b0, query_span});
			max_j_q <= NO_PRED;
			nskip_q <= '0;
		end
		if (cmd.walk_init) begin
			span_q <= walk_span[CW-1:0];
			cnt_q <= walk_span[CW-1:0];
			j_q <= i_q - 32'd1;
			j_slot_q <= slot_dec(i_slot_q);
		end
		if (cmd.stage_b) begin
			dr_s1 <= dr_b;
			dq_s1 <= dq_b;
			dd_s1 <= dd_b;
			same_s1 <= same_b;
			rej_s1 <= rej_b;
		end
		if (cmd.stage_c) begin
			sc0_s2 <= sc0_c;
			clog_s2 <= clog_c;
			clin_s2 <= prod[59:16];
			same_s2 <= same_s1;
			drz_s2 <= dr_s1 == 42'sd0;
			drgt_s2 <= dr_s1 > dq42;
			rej_s2 <= rej_c;
		end
		if (cmd.stage_d) begin
			if (!rej_s2) begin
				if (better) begin
					max_f_q <= sc;
					max_j_q <= j_q;
					maxj_slot_q <= j_slot_q;
					nskip_q <= (nskip_q == '0) ? '0 : nskip_q - 17'd1;
				end else if (mark_hit) begin
					nskip_q <= nskip_q + 17'd1;
				end
			end
			cnt_q <= cnt_q - CW'(1);
			j_q <= j_q - 32'd1;
			j_slot_q <= slot_dec(j_slot_q);
		end
		if (cmd.peak_chk) begin
			fi_q <= fi_c;
			peak_q <= peak_c;
		end
		if (cmd.finish) begin
			chain_q <= fi_q;
			pred_q <= max_j_q;
			peakout_q <= peak_q;
		end
	end

	assign out_valid = out_valid_q;
	assign chain_score = $signed(chain_q);
	assign pred_index = $signed(pred_q);
	assign peak_score = $signed(peakout_q);

endmodule
`default_nettype wire

/* rtl/core/anchor_chain_dp_scorer.sv */
// Channel  Handshake              Payload
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
// in       in_valid/in_ready      ref_key, query_pos, query_span, segment_id, last_of_read
// out      out_valid/out_ready    chain_score, pred_index, peak_score
//
// The work on one anchor grows with S, the number of window start slides, and with P,
// the number of predecessors walked (at most the iteration limit).
// Each predecessor costs one window memory read and three compute stages.
// Reset clears the counters and the window start and restores the configuration
// defaults; the window memory needs no clearing. A stalled output holds its request
// while the next anchor is accepted; the block waits only when a second result is ready.
`default_nettype none
module anchor_chain_dp_scorer #(
	parameter int WINDOW_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [63:0]        ref_key,
	input  wire logic signed [31:0] query_pos,
	input  wire logic [7:0]         query_span,
	input  wire logic [7:0]         segment_id,
	input  wire logic               last_of_read,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      chain_score,
	output logic signed [31:0]      pred_index,
	output logic signed [31:0]      peak_score
);
	import acds_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	acds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	acds_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ref_key      (ref_key),
		.query_pos    (query_pos),
		.query_span   (query_span),
		.segment_id   (segment_id),
		.last_of_read (last_of_read),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chain_score  (chain_score),
		.pred_index   (pred_index),
		.peak_score   (peak_score)
	);

endmodule
`default_nettype wire

/* rtl/core/acds_chk.sv */
`default_nettype none
`include "anchor_chain_dp_scorer_assert.svh"
module acds_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] chain_score,
	input wire logic signed [31:0] pred_index,
	input wire logic signed [31:0] peak_score
);

	`ACDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(chain_score) && $stable(pred_index) && $stable(peak_score), "stalled result changed")
	`ACDS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "anchor accepted while busy")
	`ACDS_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(!in_ready), "result without work")
	`ACDS_ASSERT_IMP(a_peak_ge_score, out_valid, peak_score >= chain_score, "peak below score")

endmodule

bind anchor_chain_dp_scorer acds_chk u_chk (.*);
`default_nettype wire
